@@ sv/ffha_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
// Holds the block header layout, the memory request and the result record.
// No dependencies.
package ffha_pkg;

  localparam int ARENA_BYTES    = 4096;
  localparam int NWORDS         = ARENA_BYTES / 4;
  localparam int AW             = $clog2(NWORDS);
  localparam int SW             = 12;
  localparam int HDR_BYTES      = 20;
  localparam int HDR_WORDS      = 5;
  localparam int RESERVED_BYTES = 24;
  localparam int INIT_FREE      = ARENA_BYTES - HDR_BYTES - RESERVED_BYTES;

  typedef struct packed {
    logic [SW-1:0] size;
    logic [AW-1:0] prev;
    logic [AW-1:0] next;
    logic          has_prev;
    logic          has_next;
    logic          used;
    logic          live;
  } hdr_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    hdr_t          wdata;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_FIT   = 2'd2
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef struct packed {
    status_e     status;
    logic [9:0]  payload_offset;
    logic [11:0] used_bytes;
    logic [11:0] free_bytes;
    logic [9:0]  block_count;
    logic [11:0] smallest_free;
    logic [11:0] largest_free;
  } result_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_A_FIT, S_A_WRB, S_A_RDN, S_A_WRN,
    S_F_HDR, S_F_PRV, S_F_NXG, S_F_NXT, S_F_RNN, S_F_WNN, S_F_WK, S_F_WH,
    S_SCAN_GO, S_SCAN, S_DONE
  } fsm_e;

endpackage

@@ sv/ffha_hdr_ram.sv @@
// Single-port header memory, one entry per arena word.
// Read data is registered; uses ffha_pkg.
module ffha_hdr_ram import ffha_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output hdr_t     rdata_o
);

  hdr_t mem [NWORDS];
  hdr_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ffha_ctrl.sv @@
// Sequencer for allocate, free and the free-chunk scan over the block chain.
// Drives the header memory port; uses ffha_pkg.
module ffha_ctrl import ffha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  kind_e       kind_i,
  input  logic [12:0] alloc_bytes_i,
  input  logic [9:0]  handle_i,
  output logic        idle_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o,
  output mem_req_t    mem_req_o,
  input  hdr_t        mem_rdata_i
);

  fsm_e          state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [12:0]   req_q, req_d;
  logic [AW-1:0] hi_q, hi_d;
  hdr_t          b_q, b_d;
  logic [AW-1:0] hs_q, hs_d;
  hdr_t          h_q, h_d;
  hdr_t          k_q, k_d;
  logic [AW-1:0] keep_q, keep_d;
  logic          merged_q, merged_d;
  logic [AW-1:0] nn_q, nn_d;
  status_e       status_q, status_d;
  logic [9:0]    off_q, off_d;
  logic [12:0]   used_q, used_d;
  logic [12:0]   free_q, free_d;
  logic [9:0]    blocks_q, blocks_d;
  logic [SW-1:0] mn_q, mn_d;
  logic [SW-1:0] mx_q, mx_d;
  logic          sc_found_q, sc_found_d;
  logic [SW-1:0] sc_mn_q, sc_mn_d;
  logic [SW-1:0] sc_mx_q, sc_mx_d;

  hdr_t          rd;
  hdr_t          init_hdr;
  logic          fit_ok;
  logic [11:0]   h_sum;
  logic [12:0]   slack;
  logic          no_split;
  logic [SW-1:0] cand_mn, cand_mx;
  logic          cand_found;
  logic          scan_end;
  logic          size_bad;
  logic          handle_bad;

  assign rd       = mem_rdata_i;
  assign fit_ok   = rd.live && !rd.used && ({1'b0, rd.size} >= req_q);
  assign h_sum    = {2'b00, cur_q} + 12'(HDR_WORDS) + {1'b0, req_q[12:2]};
  assign slack    = {1'b0, rd.size} - req_q;
  assign no_split = (slack <= 13'(HDR_BYTES)) || (h_sum[11:AW] != '0);
  assign size_bad   = (alloc_bytes_i[2:0] != 3'd0);
  assign handle_bad = (handle_i < 10'(HDR_WORDS));
  assign scan_end = !rd.live || !rd.has_next;

  always_comb begin
    init_hdr      = '0;
    init_hdr.size = SW'(INIT_FREE);
    init_hdr.live = 1'b1;
  end

  // Fold the current chain entry, if it is a free block, into the running min and max.
  always_comb begin
    cand_mn    = sc_mn_q;
    cand_mx    = sc_mx_q;
    cand_found = sc_found_q;
    if (rd.live && !rd.used) begin
      if (!sc_found_q || rd.size < sc_mn_q) begin
        cand_mn = rd.size;
      end
      if (rd.size > sc_mx_q) begin
        cand_mx = rd.size;
      end
      cand_found = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(NWORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_ALLOC) begin
            state_d = size_bad ? S_DONE : S_A_FIT;
          end else begin
            state_d = handle_bad ? S_DONE : S_F_HDR;
          end
        end
      end
      S_A_FIT: begin
        if (!rd.live) begin
          state_d = S_DONE;
        end else if (fit_ok) begin
          state_d = no_split ? S_SCAN_GO : S_A_WRB;
        end else if (!rd.has_next) begin
          state_d = S_DONE;
        end
      end
      S_A_WRB: state_d = b_q.has_next ? S_A_RDN : S_SCAN_GO;
      S_A_RDN: state_d = S_A_WRN;
      S_A_WRN: state_d = S_SCAN_GO;
      S_F_HDR: begin
        if (!rd.live || !rd.used) begin
          state_d = S_DONE;
        end else begin
          state_d = rd.has_prev ? S_F_PRV : S_F_NXG;
        end
      end
      S_F_PRV: state_d = S_F_NXG;
      S_F_NXG: state_d = h_q.has_next ? S_F_NXT : S_F_WK;
      S_F_NXT: state_d = (!rd.used && rd.has_next) ? S_F_RNN : S_F_WK;
      S_F_RNN: state_d = S_F_WNN;
      S_F_WNN: state_d = S_F_WK;
      S_F_WK:  state_d = merged_q ? S_F_WH : S_SCAN_GO;
      S_F_WH:  state_d = S_SCAN_GO;
      S_SCAN_GO: state_d = S_SCAN;
      S_SCAN: begin
        if (scan_end) state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory port and datapath
  always_comb begin
    mem_req_o  = '0;
    mem_req_o.addr = cur_q;
    clr_d      = clr_q;
    cur_d      = cur_q;
    req_d      = req_q;
    hi_d       = hi_q;
    b_d        = b_q;
    hs_d       = hs_q;
    h_d        = h_q;
    k_d        = k_q;
    keep_d     = keep_q;
    merged_d   = merged_q;
    nn_d       = nn_q;
    status_d   = status_q;
    off_d      = off_q;
    used_d     = used_q;
    free_d     = free_q;
    blocks_d   = blocks_q;
    mn_d       = mn_q;
    mx_d       = mx_q;
    sc_found_d = sc_found_q;
    sc_mn_d    = sc_mn_q;
    sc_mx_d    = sc_mx_q;
    case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = clr_q;
        mem_req_o.wdata = (clr_q == '0) ? init_hdr : '0;
        clr_d           = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (start_i) begin
          req_d    = alloc_bytes_i;
          hi_d     = AW'(handle_i - 10'(HDR_WORDS));
          status_d = ST_OK;
          off_d    = '0;
          cur_d    = '0;
          if (kind_i == KIND_ALLOC) begin
            mem_req_o.addr = '0;
            if (size_bad) status_d = ST_BAD_SIZE;
          end else begin
            mem_req_o.addr = AW'(handle_i - 10'(HDR_WORDS));
          end
        end
      end
      S_A_FIT: begin
        if (!rd.live) begin
          status_d = ST_NO_FIT;
        end else if (fit_ok) begin
          blocks_d = blocks_q + 10'd1;
          off_d    = 10'(cur_q + AW'(HDR_WORDS));
          b_d      = rd;
          b_d.used = 1'b1;
          hs_d     = h_sum[AW-1:0];
          if (no_split) begin
            free_d = free_q - {1'b0, rd.size};
            used_d = used_q + {1'b0, rd.size};
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = cur_q;
            mem_req_o.wdata = b_d;
          end else begin
            free_d = free_q - (req_q + 13'(HDR_BYTES));
            used_d = used_q + (req_q + 13'(HDR_BYTES));
            mem_req_o.we             = 1'b1;
            mem_req_o.addr           = h_sum[AW-1:0];
            mem_req_o.wdata.size     = SW'(slack - 13'(HDR_BYTES));
            mem_req_o.wdata.prev     = cur_q;
            mem_req_o.wdata.has_prev = 1'b1;
            mem_req_o.wdata.next     = rd.next;
            mem_req_o.wdata.has_next = rd.has_next;
            mem_req_o.wdata.used     = 1'b0;
            mem_req_o.wdata.live     = 1'b1;
          end
        end else if (!rd.has_next) begin
          status_d = ST_NO_FIT;
        end else begin
          cur_d          = rd.next;
          mem_req_o.addr = rd.next;
        end
      end
      S_A_WRB: begin
        mem_req_o.we             = 1'b1;
        mem_req_o.addr           = cur_q;
        mem_req_o.wdata          = b_q;
        mem_req_o.wdata.size     = SW'(req_q);
        mem_req_o.wdata.next     = hs_q;
        mem_req_o.wdata.has_next = 1'b1;
      end
      S_A_RDN: begin
        mem_req_o.addr = b_q.next;
      end
      S_A_WRN: begin
        mem_req_o.we             = 1'b1;
        mem_req_o.addr           = b_q.next;
        mem_req_o.wdata          = rd;
        mem_req_o.wdata.prev     = hs_q;
        mem_req_o.wdata.has_prev = 1'b1;
      end
      S_F_HDR: begin
        if (rd.live && rd.used) begin
          free_d   = free_q + {1'b0, rd.size};
          used_d   = used_q - {1'b0, rd.size};
          blocks_d = blocks_q - 10'd1;
          h_d      = rd;
          h_d.used = 1'b0;
          k_d      = h_d;
          keep_d   = hi_q;
          merged_d = 1'b0;
          mem_req_o.addr = rd.prev;
        end
      end
      S_F_PRV: begin
        if (!rd.used) begin
          k_d          = rd;
          k_d.next     = h_q.next;
          k_d.has_next = h_q.has_next;
          k_d.size     = rd.size + h_q.size + SW'(HDR_BYTES);
          keep_d       = h_q.prev;
          merged_d     = 1'b1;
          free_d       = free_q + 13'(HDR_BYTES);
          used_d       = used_q - 13'(HDR_BYTES);
        end
      end
      S_F_NXG: begin
        mem_req_o.addr = h_q.next;
      end
      S_F_NXT: begin
        // Relink the successor; drop it when it folds into the kept block.
        mem_req_o.we             = 1'b1;
        mem_req_o.addr           = h_q.next;
        mem_req_o.wdata          = rd;
        mem_req_o.wdata.prev     = keep_q;
        mem_req_o.wdata.has_prev = 1'b1;
        if (!rd.used) begin
          mem_req_o.wdata.live = 1'b0;
          k_d.size     = k_q.size + rd.size + SW'(HDR_BYTES);
          k_d.next     = rd.next;
          k_d.has_next = rd.has_next;
          nn_d         = rd.next;
          free_d       = free_q + 13'(HDR_BYTES);
          used_d       = used_q - 13'(HDR_BYTES);
        end
      end
      S_F_RNN: begin
        mem_req_o.addr = nn_q;
      end
      S_F_WNN: begin
        mem_req_o.we             = 1'b1;
        mem_req_o.addr           = nn_q;
        mem_req_o.wdata          = rd;
        mem_req_o.wdata.prev     = keep_q;
        mem_req_o.wdata.has_prev = 1'b1;
      end
      S_F_WK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = keep_q;
        mem_req_o.wdata = k_q;
      end
      S_F_WH: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.addr       = hi_q;
        mem_req_o.wdata      = h_q;
        mem_req_o.wdata.live = 1'b0;
      end
      S_SCAN_GO: begin
        mem_req_o.addr = '0;
        sc_found_d     = 1'b0;
        sc_mn_d        = '0;
        sc_mx_d        = '0;
      end
      S_SCAN: begin
        sc_found_d = cand_found;
        sc_mn_d    = cand_mn;
        sc_mx_d    = cand_mx;
        mem_req_o.addr = rd.next;
        if (scan_end) begin
          mn_d = cand_found ? cand_mn : '0;
          mx_d = cand_mx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      used_q     <= 13'(HDR_BYTES);
      free_q     <= 13'(INIT_FREE);
      blocks_q   <= '0;
      mn_q       <= SW'(INIT_FREE);
      mx_q       <= SW'(INIT_FREE);
      merged_q   <= 1'b0;
      status_q   <= ST_OK;
      off_q      <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      used_q     <= used_d;
      free_q     <= free_d;
      blocks_q   <= blocks_d;
      mn_q       <= mn_d;
      mx_q       <= mx_d;
      merged_q   <= merged_d;
      status_q   <= status_d;
      off_q      <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    req_q      <= req_d;
    hi_q       <= hi_d;
    b_q        <= b_d;
    hs_q       <= hs_d;
    h_q        <= h_d;
    k_q        <= k_d;
    keep_q     <= keep_d;
    nn_q       <= nn_d;
    sc_found_q <= sc_found_d;
    sc_mn_q    <= sc_mn_d;
    sc_mx_q    <= sc_mx_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.status         = status_q;
    res_o.payload_offset = off_q;
    res_o.used_bytes     = used_q[11:0];
    res_o.free_bytes     = free_q[11:0];
    res_o.block_count    = blocks_q;
    res_o.smallest_free  = mn_q;
    res_o.largest_free   = mx_q;
  end

endmodule

@@ sv/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator: stream ports, result register, sequencer, header RAM.
// The fit walk and the free-chunk scan visit the chain blocks one at a time; an
// allocate or a free adds header updates and hand-off to the output register.
// Throughput: one item at a time; a new item is taken only while the sequencer is idle.
// Reset: a clearing pass over all 1024 header RAM entries, no item taken meanwhile.
// Uses ffha_pkg, ffha_ctrl and ffha_hdr_ram.
module first_fit_heap_allocator_unit import ffha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // alloc_bytes[12:0], handle[22:13]
  input  logic [0:0]  s_axis_tuser,  // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // status, payload_offset, used_bytes, free_bytes,
                                     // block_count, smallest_free, largest_free
);

  logic     start;
  logic     idle;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  mem_req_t mem_req;
  hdr_t     mem_rdata;
  logic     m_valid_q;
  logic [71:0] m_data_q;

  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;
  assign res_ready     = !m_valid_q || m_axis_tready;

  ffha_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .kind_i        (kind_e'(s_axis_tuser[0])),
    .alloc_bytes_i (s_axis_tdata[12:0]),
    .handle_i      (s_axis_tdata[22:13]),
    .idle_o        (idle),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  ffha_hdr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Hold the finished beat so the sequencer can take the next item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= {2'b00, res.largest_free, res.smallest_free, res.block_count,
                   res.free_bytes, res.used_bytes, res.payload_offset, res.status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
